@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the neighbor table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge outside of reset.
`define MNTF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every rising clock edge, reset included.
`define MNTF_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ rtl/mntf_pkg.sv @@
// ----------------------------------------------------------------------------
// mntf_pkg
// Types, constants and helpers for the mesh neighbor table forwarder.
// ----------------------------------------------------------------------------
`default_nettype none

package mntf_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  localparam int ID_W   = 32;
  localparam int TIME_W = 32;
  localparam int HOP_W  = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOP_LIMIT = 2'd3;

  // Input kinds carried on tuser.
  localparam logic ACT_PACKET = 1'b0;
  localparam logic ACT_SWEEP  = 1'b1;

  // Table status codes.
  localparam logic [2:0] STAT_UPDATED = 3'd0;
  localparam logic [2:0] STAT_INSERTED = 3'd1;
  localparam logic [2:0] STAT_FULL    = 3'd2;
  localparam logic [2:0] STAT_IGNORED = 3'd3;
  localparam logic [2:0] STAT_SWEEP   = 3'd4;

  // Input item on s_tdata, last field (dest_id) in the lowest bits.
  typedef struct packed {
    logic [6:0]        pad;
    logic [TIME_W-1:0] now_ms;
    logic signed [7:0] signal_snr;
    logic signed [8:0] signal_rssi;
    logic [HOP_W-1:0]  hop_count;
    logic [ID_W-1:0]   source_id;
    logic [ID_W-1:0]   dest_id;
  } in_item_t;

  // Result item on m_tdata, last field (for_us) in the lowest bits.
  typedef struct packed {
    logic [4:0]       pad;
    logic [4:0]       online_count;
    logic [4:0]       went_offline;
    logic [3:0]       entry_index;
    logic [2:0]       table_status;
    logic [HOP_W-1:0] forward_hops;
    logic             forward;
    logic             for_us;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic              full;   // full entry write, else only the online flag is cleared
    logic [IDX_W-1:0]  idx;
    logic [ID_W-1:0]   node_id;
    logic [TIME_W-1:0] last_heard;
  } tbl_wr_t;

  typedef struct packed {
    logic [ID_W-1:0]   node_id;
    logic              online;
    logic [TIME_W-1:0] last_heard;
  } tbl_rd_t;

  typedef struct packed {
    logic live;      // occupied and online
    logic stale;     // live and silent for longer than the timeout
    logic id_match;
    logic id_free;
  } entry_eval_t;

  function automatic logic [4:0] sat_count(input logic [8:0] n);
    logic [4:0] r;
    r = (n > 9'd31) ? 5'd31 : n[4:0];
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/mntf_table.sv @@
// ----------------------------------------------------------------------------
// mntf_table
// Neighbor table storage: ids and online flags in resettable flops, last heard
// times in a memory. One registered read and one write per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mntf_table (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         rd_en,
  input  wire  [mntf_pkg::IDX_W-1:0]  rd_idx,
  output mntf_pkg::tbl_rd_t           rd,
  input  mntf_pkg::tbl_wr_t           wr
);
  import mntf_pkg::*;

  logic [ID_W-1:0]   node_id    [TABLE_ENTRIES];
  logic              online     [TABLE_ENTRIES];
  logic [TIME_W-1:0] last_heard [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        node_id[i] <= '0;
        online[i]  <= 1'b0;
      end
    end else if (wr.en) begin
      if (wr.full) begin
        node_id[wr.idx] <= wr.node_id;
        online[wr.idx]  <= 1'b1;
      end else begin
        online[wr.idx]  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.full) begin
      last_heard[wr.idx] <= wr.last_heard;
    end
    if (rd_en) begin
      rd.node_id    <= node_id[rd_idx];
      rd.online     <= online[rd_idx];
      rd.last_heard <= last_heard[rd_idx];
    end
  end

endmodule

`default_nettype wire

@@ rtl/mntf_entry_unit.sv @@
// ----------------------------------------------------------------------------
// mntf_entry_unit
// Shared evaluation unit: one id compare and one wrapping age subtract and
// compare, applied to one table entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mntf_entry_unit (
  input  mntf_pkg::tbl_rd_t              rd,
  input  wire  [mntf_pkg::ID_W-1:0]      source_id,
  input  wire  [mntf_pkg::TIME_W-1:0]    now_ms,
  input  wire  [mntf_pkg::TIME_W-1:0]    timeout_ms,
  output mntf_pkg::entry_eval_t          ev
);
  import mntf_pkg::*;

  logic [TIME_W-1:0] age;
  logic              occupied;

  always_comb begin
    occupied    = (rd.node_id != '0);
    age         = now_ms - rd.last_heard;
    ev.live     = occupied && rd.online;
    ev.stale    = ev.live && (age > timeout_ms);
    ev.id_match = (rd.node_id == source_id);
    ev.id_free  = !occupied;
  end

endmodule

`default_nettype wire

@@ rtl/mesh_neighbor_table_forwarder_top.sv @@
// ----------------------------------------------------------------------------
// mesh_neighbor_table_forwarder_top
// Mesh packet filter with a neighbor table that ages out silent nodes.
// ----------------------------------------------------------------------------
// Input items arrive on s_tvalid/s_tready/s_tdata with s_tuser selecting a
// received packet header (0) or an age sweep (1). Each item yields exactly one
// result item on m_tvalid/m_tready/m_tdata: the for-us and forward decision,
// the table outcome and the online neighbor count.
// Every item walks the whole table, one entry per cycle through the table's
// single registered read port and the shared compare unit. The result shows
// on m_tvalid after the scan and the UPDATE and FINISH states, and s_tready
// rises in the same cycle as the result, so a new item is taken only once
// the last one's result has been registered.
// s_tready is low while an item is being processed.
// A stalled receiver holds the result in the output register; the next input
// item is still taken and processed, and its result waits until the held
// one leaves.
// Synchronous reset empties the table, marks all entries offline and loads
// the register defaults. Configuration writes on cfg_we/cfg_index/cfg_data
// take effect at once and are meant to be made while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mesh_neighbor_table_forwarder_top (
  input  wire                               clk,
  input  wire                               rst,
  // s_tdata: dest_id, source_id, hop_count, signal_rssi, signal_snr, now_ms
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire  [127:0]                      s_tdata,
  // s_tuser: action
  input  wire  [0:0]                        s_tuser,
  // m_tdata: for_us, forward, forward_hops, table_status, entry_index,
  //          went_offline, online_count
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [31:0]                       m_tdata,
  input  wire                               cfg_we,
  input  wire  [mntf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire  [mntf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mntf_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE, ST_FINISH} state_t;

  // Configuration registers.
  logic [ID_W-1:0]   own_node_id;
  logic [ID_W-1:0]   broadcast_id;
  logic [TIME_W-1:0] node_timeout_ms;
  logic [HOP_W-1:0]  hop_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_node_id     <= '0;
      broadcast_id    <= '1;
      node_timeout_ms <= TIME_W'(300000);
      hop_limit       <= HOP_W'(3);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OWN_ID:    own_node_id     <= cfg_data;
        CFG_BCAST_ID:  broadcast_id    <= cfg_data;
        CFG_TIMEOUT:   node_timeout_ms <= cfg_data;
        CFG_HOP_LIMIT: hop_limit       <= cfg_data[HOP_W-1:0];
        default: ;
      endcase
    end
  end

  in_item_t    s_item;
  state_t      state;
  logic        issue_busy;
  logic [IDX_W-1:0] issue_idx;
  logic        eval_vld;
  logic [IDX_W-1:0] eval_idx;

  // Captured item and decisions.
  logic              act_sweep;
  logic [ID_W-1:0]   src_id;
  logic [TIME_W-1:0] now_ms;
  logic              mine;
  logic              ignored;
  logic              fwd;
  logic [HOP_W-1:0]  fwd_hops;

  // Scan results.
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic              found_live;
  logic              have_free;
  logic [IDX_W-1:0]  free_idx;
  logic [CNT_W-1:0]  live_cnt;
  logic [CNT_W-1:0]  offl_cnt;
  logic [2:0]        res_status;
  logic [IDX_W-1:0]  res_slot;

  out_item_t   res;
  tbl_rd_t     tbl_rd;
  tbl_wr_t     tbl_wr;
  entry_eval_t ev;
  logic [7:0]  slot8;

  assign s_item   = in_item_t'(s_tdata);
  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = res;
  assign slot8    = 8'(res_slot);

  mntf_table u_table (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (issue_busy),
    .rd_idx (issue_idx),
    .rd     (tbl_rd),
    .wr     (tbl_wr)
  );

  mntf_entry_unit u_entry (
    .rd         (tbl_rd),
    .source_id  (src_id),
    .now_ms     (now_ms),
    .timeout_ms (node_timeout_ms),
    .ev         (ev)
  );

  always_comb begin
    tbl_wr            = '0;
    tbl_wr.node_id    = src_id;
    tbl_wr.last_heard = now_ms;
    if (state == ST_SCAN && eval_vld && act_sweep && ev.stale) begin
      tbl_wr.en  = 1'b1;
      tbl_wr.idx = eval_idx;
    end else if (state == ST_UPDATE && !act_sweep && !ignored && (found || have_free)) begin
      tbl_wr.en   = 1'b1;
      tbl_wr.full = 1'b1;
      tbl_wr.idx  = found ? found_idx : free_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      issue_busy <= 1'b0;
      eval_vld   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_FINISH) begin
        m_tvalid <= 1'b0;
      end
      eval_vld <= issue_busy;
      eval_idx <= issue_idx;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            act_sweep  <= (s_tuser[0] == ACT_SWEEP);
            src_id     <= s_item.source_id;
            now_ms     <= s_item.now_ms;
            mine       <= (s_item.dest_id == own_node_id) ||
                          (s_item.dest_id == broadcast_id);
            ignored    <= (s_item.source_id == own_node_id) ||
                          (s_item.source_id == broadcast_id) ||
                          (s_item.source_id == '0);
            fwd        <= (s_item.dest_id != own_node_id) &&
                          (s_item.dest_id != broadcast_id) &&
                          (s_item.hop_count < hop_limit);
            fwd_hops   <= s_item.hop_count + HOP_W'(1);
            found      <= 1'b0;
            found_idx  <= '0;
            found_live <= 1'b0;
            have_free  <= 1'b0;
            free_idx   <= '0;
            live_cnt   <= '0;
            offl_cnt   <= '0;
            issue_busy <= 1'b1;
            issue_idx  <= '0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (issue_busy) begin
            if (issue_idx == LAST_IDX) begin
              issue_busy <= 1'b0;
            end else begin
              issue_idx <= issue_idx + IDX_W'(1);
            end
          end
          if (eval_vld) begin
            if (act_sweep) begin
              if (ev.stale) begin
                offl_cnt <= offl_cnt + CNT_W'(1);
              end else if (ev.live) begin
                live_cnt <= live_cnt + CNT_W'(1);
              end
            end else begin
              if (ev.live) begin
                live_cnt <= live_cnt + CNT_W'(1);
              end
              if (!ignored && !found && ev.id_match) begin
                found      <= 1'b1;
                found_idx  <= eval_idx;
                found_live <= ev.live;
              end
              if (!have_free && ev.id_free) begin
                have_free <= 1'b1;
                free_idx  <= eval_idx;
              end
            end
            if (eval_idx == LAST_IDX) begin
              state <= ST_UPDATE;
            end
          end
        end
        ST_UPDATE: begin
          if (act_sweep) begin
            res_status <= STAT_SWEEP;
            res_slot   <= '0;
          end else if (ignored) begin
            res_status <= STAT_IGNORED;
            res_slot   <= '0;
          end else if (found) begin
            // A matched entry that was offline comes back online.
            res_status <= STAT_UPDATED;
            res_slot   <= found_idx;
            if (!found_live) begin
              live_cnt <= live_cnt + CNT_W'(1);
            end
          end else if (have_free) begin
            res_status <= STAT_INSERTED;
            res_slot   <= free_idx;
            live_cnt   <= live_cnt + CNT_W'(1);
          end else begin
            res_status <= STAT_FULL;
            res_slot   <= '0;
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            res.pad          <= '0;
            res.for_us       <= !act_sweep && mine;
            res.forward      <= !act_sweep && fwd;
            res.forward_hops <= (!act_sweep && fwd) ? fwd_hops : '0;
            res.table_status <= res_status;
            res.entry_index  <= slot8[3:0];
            res.went_offline <= sat_count(9'(offl_cnt));
            res.online_count <= sat_count(9'(live_cnt));
            m_tvalid         <= 1'b1;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `MNTF_ASSERT(a_idle_no_scan, (state == ST_IDLE) |-> (!issue_busy && !eval_vld), "scan active while idle")
  `MNTF_ASSERT(a_full_write_in_update, (tbl_wr.en && tbl_wr.full) |-> (state == ST_UPDATE), "entry write outside update")
  `MNTF_ASSERT(a_accept_starts_scan, (s_tvalid && s_tready) |=> (state == ST_SCAN && issue_busy), "accepted item did not start a scan")
  `MNTF_ASSERT(a_sweep_result_clean, (m_tvalid && res.table_status == STAT_SWEEP) |-> (!res.for_us && !res.forward && res.entry_index == 4'd0), "sweep result carries packet fields")
  `MNTF_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == ST_IDLE && !m_tvalid), "reset did not return to idle")

endmodule

`default_nettype wire

@@ tb/mntf_outcome_checker.sv @@
// ----------------------------------------------------------------------------
// mntf_outcome_checker
// Watches the input, result and register ports of the neighbor table
// forwarder. It keeps its own copy of the table and registers, works out the
// result of every accepted input item, and compares each accepted result
// with the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mntf_outcome_checker (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              s_tvalid,
  input  wire                              s_tready,
  input  wire  [127:0]                     s_tdata,
  input  wire  [0:0]                       s_tuser,
  input  wire                              m_tvalid,
  input  wire                              m_tready,
  input  wire  [31:0]                      m_tdata,
  input  wire                              cfg_we,
  input  wire  [mntf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [mntf_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               outstanding
);

  import mntf_pkg::*;

  logic [ID_W-1:0]   own_id;
  logic [ID_W-1:0]   bcast_id;
  logic [TIME_W-1:0] timeout_ms;
  logic [HOP_W-1:0]  hop_lim;

  // Only the entry fields that reach a result are kept.
  logic [ID_W-1:0]   nbr_id     [TABLE_ENTRIES];
  logic [TIME_W-1:0] nbr_heard  [TABLE_ENTRIES];
  logic              nbr_online [TABLE_ENTRIES];

  out_item_t pending_outcomes[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  // Applies one item to the table copy and returns the result it gives.
  function automatic out_item_t table_outcome(input logic act, input in_item_t pkt);
    out_item_t         res;
    logic              mine;
    logic              hit;
    int                slot;
    int                n_off;
    int                n_on;
    logic [TIME_W-1:0] silence;
    res   = '0;
    n_off = 0;
    n_on  = 0;
    if (act == ACT_SWEEP) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        silence = pkt.now_ms - nbr_heard[i];
        if (nbr_id[i] != '0 && nbr_online[i] && silence > timeout_ms) begin
          nbr_online[i] = 1'b0;
          n_off++;
        end
      end
      res.table_status = STAT_SWEEP;
    end else begin
      mine       = (pkt.dest_id == own_id) || (pkt.dest_id == bcast_id);
      res.for_us = mine;
      if (pkt.source_id == own_id || pkt.source_id == bcast_id || pkt.source_id == '0) begin
        res.table_status = STAT_IGNORED;
      end else begin
        slot = -1;
        hit  = 1'b0;
        // A matching id wins over any free slot, even an earlier one.
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (!hit && nbr_id[i] == pkt.source_id) begin
            slot = i;
            hit  = 1'b1;
          end else if (!hit && slot < 0 && nbr_id[i] == '0) begin
            slot = i;
          end
        end
        if (slot < 0) begin
          res.table_status = STAT_FULL;
        end else begin
          nbr_id[slot]     = pkt.source_id;
          nbr_heard[slot]  = pkt.now_ms;
          nbr_online[slot] = 1'b1;
          res.table_status = hit ? STAT_UPDATED : STAT_INSERTED;
          res.entry_index  = slot[3:0];
        end
      end
      if (!mine && pkt.hop_count < hop_lim) begin
        res.forward      = 1'b1;
        res.forward_hops = pkt.hop_count + 8'd1;
      end
    end
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (nbr_id[i] != '0 && nbr_online[i]) n_on++;
    end
    res.went_offline = (n_off > 31) ? 5'd31 : 5'(n_off);
    res.online_count = (n_on > 31) ? 5'd31 : 5'(n_on);
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (rst) begin
      own_id     = '0;
      bcast_id   = '1;
      timeout_ms = 32'd300000;
      hop_lim    = 8'd3;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        nbr_id[i]     = '0;
        nbr_heard[i]  = '0;
        nbr_online[i] = 1'b0;
      end
      pending_outcomes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_OWN_ID:    own_id     = cfg_data;
          CFG_BCAST_ID:  bcast_id   = cfg_data;
          CFG_TIMEOUT:   timeout_ms = cfg_data;
          CFG_HOP_LIMIT: hop_lim    = cfg_data[HOP_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = out_item_t'(m_tdata);
        if (pending_outcomes.size() == 0) begin
          report_mismatch("result with no item outstanding", m_tdata, 0);
        end else begin
          want = pending_outcomes.pop_front();
          if (got.for_us != want.for_us)
            report_mismatch("for_us", got.for_us, want.for_us);
          if (got.forward != want.forward)
            report_mismatch("forward", got.forward, want.forward);
          if (got.forward_hops != want.forward_hops)
            report_mismatch("forward_hops", got.forward_hops, want.forward_hops);
          if (got.table_status != want.table_status)
            report_mismatch("table_status", got.table_status, want.table_status);
          if (got.entry_index != want.entry_index)
            report_mismatch("entry_index", got.entry_index, want.entry_index);
          if (got.went_offline != want.went_offline)
            report_mismatch("went_offline", got.went_offline, want.went_offline);
          if (got.online_count != want.online_count)
            report_mismatch("online_count", got.online_count, want.online_count);
          if (got.pad != want.pad)
            report_mismatch("padding bits", got.pad, want.pad);
        end
      end
      if (s_tvalid && s_tready) begin
        pending_outcomes.push_back(table_outcome(s_tuser[0], in_item_t'(s_tdata)));
      end
    end
    outstanding = pending_outcomes.size();
  end

endmodule

@@ tb/tb_mesh_neighbor_table_forwarder_top.sv @@
// ----------------------------------------------------------------------------
// tb_mesh_neighbor_table_forwarder_top
// Drives packet headers and age sweeps into the neighbor table forwarder:
// a directed pass that fills the table, overflows it and ages entries across
// the time wrap, then random traffic under several register settings with
// random idle gaps on both sides. The checker beside the block judges every
// result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mesh_neighbor_table_forwarder_top;

  import mntf_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int POOL_SIZE   = 24;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 250;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [127:0]          s_tdata   = '0;
  logic [0:0]            s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b1;
  logic [31:0]           m_tdata;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count;
  int outstanding;
  int stall_left = 0;
  logic calm = 1'b0;

  logic [31:0] id_pool [POOL_SIZE];
  logic [31:0] own_id;
  logic [31:0] bcast_id;
  logic [31:0] timeout_ms;
  logic [31:0] clock_ms;
  logic [7:0]  hop_lim;

  mesh_neighbor_table_forwarder_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mntf_outcome_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short pauses, now and then a long one.
  function automatic int idle_span();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      m_tready   <= 1'b0;
      stall_left <= idle_span() - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic push_item(input logic act, input logic [31:0] dest, input logic [31:0] src,
                           input logic [7:0] hops, input logic [8:0] rssi,
                           input logic [7:0] snr, input logic [31:0] now);
    in_item_t pkt;
    int       gap;
    gap = (calm || $urandom_range(0, 99) < 50) ? 0 : idle_span();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pkt             = '0;
    pkt.dest_id     = dest;
    pkt.source_id   = src;
    pkt.hop_count   = hops;
    pkt.signal_rssi = rssi;
    pkt.signal_snr  = snr;
    pkt.now_ms      = now;
    s_tdata  <= pkt;
    s_tuser  <= act;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Holds the sender back until every outstanding result has been taken.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(input logic [31:0] own, input logic [31:0] bcast,
                                input logic [31:0] tmo, input logic [7:0] hop);
    settle();
    write_reg(CFG_OWN_ID, own);
    write_reg(CFG_BCAST_ID, bcast);
    write_reg(CFG_TIMEOUT, tmo);
    write_reg(CFG_HOP_LIMIT, {24'd0, hop});
    own_id     = own;
    bcast_id   = bcast;
    timeout_ms = tmo;
    hop_lim    = hop;
  endtask

  task automatic random_item();
    int          r;
    logic [31:0] dest;
    logic [31:0] src;
    logic [31:0] step;
    logic [7:0]  hops;
    r = $urandom_range(0, 99);
    if (r < 50) step = $urandom_range(0, 1000);
    else if (r < 85) step = $urandom_range(0, timeout_ms >> 2);
    else step = $urandom;
    clock_ms = clock_ms + step;
    // Most senders come from a pool a bit larger than the table.
    r = $urandom_range(0, 99);
    if (r < 75) src = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (r < 82) src = own_id;
    else if (r < 88) src = bcast_id;
    else if (r < 91) src = '0;
    else src = $urandom;
    r = $urandom_range(0, 99);
    if (r < 25) dest = own_id;
    else if (r < 40) dest = bcast_id;
    else if (r < 60) dest = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    else dest = $urandom;
    if ($urandom_range(0, 1) == 1) hops = 8'($urandom);
    else hops = 8'($urandom_range(0, int'(hop_lim) + 1));
    push_item(($urandom_range(0, 99) < 15) ? ACT_SWEEP : ACT_PACKET, dest, src, hops,
              9'($urandom), 8'($urandom), clock_ms);
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

  initial begin
    logic [31:0] t0;
    logic [31:0] dest;
    logic [8:0]  rssi;
    logic [7:0]  snr;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      id_pool[i] = $urandom;
      if (id_pool[i] == '0 || id_pool[i] == '1) id_pool[i] = 32'h1357_9BDF + i;
    end
    own_id     = '0;
    bcast_id   = '1;
    timeout_ms = 32'd300000;
    hop_lim    = 8'd3;
    write_reg(CFG_OWN_ID, 32'hA5A5_0001);
    own_id = 32'hA5A5_0001;

    // Directed pass, starting just before the time counter wraps.
    t0 = 32'hFFFF_F000;
    push_item(ACT_SWEEP, '0, '0, '0, '0, '0, t0);
    push_item(ACT_PACKET, own_id, '0, 8'd0, 9'd0, 8'd0, t0);
    push_item(ACT_PACKET, bcast_id, own_id, 8'hFF, 9'd0, 8'd0, t0);
    push_item(ACT_PACKET, '0, bcast_id, 8'd0, 9'd0, 8'd0, t0);
    for (int i = 0; i < 16; i++) begin
      dest = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom;
      rssi = (i == 3) ? 9'h100 : (i == 4) ? 9'h0FF : 9'($urandom);
      snr  = (i == 5) ? 8'h80 : (i == 6) ? 8'h7F : 8'($urandom);
      push_item(ACT_PACKET, dest, id_pool[i], (i == 2) ? 8'hFF : 8'(i % 4), rssi, snr,
                t0 + 32'(i) * 32'd1000);
    end
    // Table is full now, then an existing sender is refreshed.
    push_item(ACT_PACKET, $urandom, id_pool[16], 8'd1, 9'd0, 8'd0, t0 + 32'd17000);
    push_item(ACT_PACKET, $urandom, id_pool[5], 8'd2, 9'd0, 8'd0, t0 + 32'd20000);
    // Silence exactly at the timeout keeps an entry online; one more ms does not.
    push_item(ACT_SWEEP, '0, '0, '0, '0, '0, t0 + timeout_ms);
    push_item(ACT_SWEEP, '0, '0, '0, '0, '0, t0 + timeout_ms + 32'd1);
    push_item(ACT_SWEEP, '1, '1, '1, '1, '1, t0 + 32'h8000_0000);
    clock_ms = t0 + 32'h8000_0000;

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_settings($urandom, 32'hFFFF_FFFF, 32'd300000, 8'd3);
        1: apply_settings(32'h0, 32'h0, 32'h0, 8'h00);
        2: apply_settings(32'hFFFF_FFFF, $urandom, 32'hFFFF_FFFF, 8'hFF);
        3: apply_settings(id_pool[3], id_pool[5], 32'd5000, 8'd8);
        default: apply_settings($urandom, $urandom, $urandom_range(0, 2_000_000),
                                8'($urandom));
      endcase
      calm = (p % 3 == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) random_item();
    end

    calm = 1'b0;
    settle();
    repeat (30) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
